// ----- rtl/core/tank_refill_drain_controller_core_defines.svh -----
// Assertion macros for the tank refill and drain controller core.
// Used by the port checker; no other dependencies.
`ifndef TANK_REFILL_DRAIN_CONTROLLER_CORE_DEFINES_SVH
`define TANK_REFILL_DRAIN_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TRDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define TRDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/trdc_pkg.sv -----
// Shared types and codes for the tank refill and drain controller core.
// No dependencies.
package trdc_pkg;

    localparam int CONFIRM_W = 8;
    localparam int TIMEOUT_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HARDWARE_READY = 2'd2;

    localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = 8'd3;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10000;

    typedef enum logic [2:0] {
        CMD_TICK        = 3'd0,
        CMD_SAMPLE      = 3'd1,
        CMD_START_MON   = 3'd2,
        CMD_STOP_MON    = 3'd3,
        CMD_START_DRAIN = 3'd4,
        CMD_STOP_DRAIN  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        LEV_NONE   = 2'd0,
        LEV_NORMAL = 2'd1,
        LEV_LOW    = 2'd2
    } t_lev;

    typedef enum logic [3:0] {
        ACT_NONE              = 4'd0,
        ACT_REFILL_START      = 4'd1,
        ACT_REFILL_STOP       = 4'd2,
        ACT_INLET_CLOSE_FAIL  = 4'd3,
        ACT_TIMEOUT           = 4'd4,
        ACT_SENSOR_FAIL       = 4'd5,
        ACT_OUTLET_CLOSE_FAIL = 4'd6,
        ACT_INLET_OPEN_FAIL   = 4'd7,
        ACT_DRAIN_START       = 4'd8,
        ACT_DRAIN_FAIL        = 4'd9,
        ACT_DRAIN_STOP        = 4'd10,
        ACT_MON_START         = 4'd11,
        ACT_NOT_READY         = 4'd12,
        ACT_REFILL_IGNORED    = 4'd13,
        ACT_MON_STOP          = 4'd14
    } t_act;

    typedef struct packed {
        logic                 monitor;
        logic                 refill;
        logic                 drain;
        logic                 fault;
        logic                 level_known;
        logic                 last_level;
        logic                 inlet;
        logic                 outlet;
        logic [CONFIRM_W-1:0] low_count;
    } t_state;

    typedef struct packed {
        logic [CONFIRM_W-1:0] confirm_samples;
        logic [TIMEOUT_W-1:0] refill_timeout_ticks;
        logic                 hardware_ready;
    } t_cfg;

endpackage

// ----- rtl/core/tank_refill_drain_controller_core.sv -----
// Tank refill and drain controller: takes one command word per cycle, unless
// the input stalls, and returns one status word per command. A word accepted
// at the input is held in the input register; its result is loaded into the
// result register, which drives the output ports, when that register is
// empty or its word is being taken. A new word is taken every cycle; the
// input stalls only while both registers hold a word and the output is
// stalled. The single next-state pass between the two registers holds all
// per-word logic. Depends on trdc_pkg, trdc_cfg_regs and trdc_step.
module tank_refill_drain_controller_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [2:0]                      i_command,
    input  logic                            i_level_full,
    input  logic                            i_sensor_error,
    input  logic                            i_inlet_fault,
    input  logic                            i_outlet_fault,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_inlet_open,
    output logic                            o_outlet_open,
    output logic                            o_refilling,
    output logic                            o_draining,
    output logic                            o_fault_latched,
    output logic                            o_monitoring,
    output logic [1:0]                      o_level_event,
    output logic [3:0]                      o_action_event,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [trdc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [trdc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    trdc_pkg::t_cfg        cfg;
    trdc_pkg::t_state      r_state;
    trdc_pkg::t_state      n_state;
    logic [TIMER_BITS-1:0] r_elapsed;
    logic [TIMER_BITS-1:0] n_elapsed;
    trdc_pkg::t_lev        n_lev;
    trdc_pkg::t_act        n_act;

    logic                  r_in_valid;
    logic [2:0]            r_command;
    logic                  r_level_full;
    logic                  r_sensor_error;
    logic                  r_inlet_fault;
    logic                  r_outlet_fault;

    logic                  r_out_valid;
    trdc_pkg::t_state      r_out_state;
    trdc_pkg::t_lev        r_out_lev;
    trdc_pkg::t_act        r_out_act;

    logic                  advance;
    logic                  in_take;

    trdc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    trdc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_state        (r_state),
        .i_elapsed      (r_elapsed),
        .i_cfg          (cfg),
        .i_command      (r_command),
        .i_level_full   (r_level_full),
        .i_sensor_error (r_sensor_error),
        .i_inlet_fault  (r_inlet_fault),
        .i_outlet_fault (r_outlet_fault),
        .o_state        (n_state),
        .o_elapsed      (n_elapsed),
        .o_level_event  (n_lev),
        .o_action_event (n_act)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_command      <= i_command;
            r_level_full   <= i_level_full;
            r_sensor_error <= i_sensor_error;
            r_inlet_fault  <= i_inlet_fault;
            r_outlet_fault <= i_outlet_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= '0;
            r_elapsed <= '0;
        end else if (advance) begin
            r_state   <= n_state;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_state <= n_state;
            r_out_lev   <= n_lev;
            r_out_act   <= n_act;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_inlet_open    = r_out_state.inlet;
    assign o_outlet_open   = r_out_state.outlet;
    assign o_refilling     = r_out_state.refill;
    assign o_draining      = r_out_state.drain;
    assign o_fault_latched = r_out_state.fault;
    assign o_monitoring    = r_out_state.monitor;
    assign o_level_event   = r_out_lev;
    assign o_action_event  = r_out_act;

endmodule

// ----- rtl/core/trdc_cfg_regs.sv -----
// Configuration register file of the tank refill and drain controller core.
// Depends on trdc_pkg.
module trdc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [trdc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [trdc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output trdc_pkg::t_cfg                    o_cfg
);

    trdc_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.confirm_samples      <= trdc_pkg::CONFIRM_RESET;
            r_cfg.refill_timeout_ticks <= trdc_pkg::TIMEOUT_RESET;
            r_cfg.hardware_ready       <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                trdc_pkg::CFG_CONFIRM_SAMPLES: begin
                    r_cfg.confirm_samples <= i_cfg_data[trdc_pkg::CONFIRM_W-1:0];
                end
                trdc_pkg::CFG_REFILL_TIMEOUT: begin
                    r_cfg.refill_timeout_ticks <= i_cfg_data[trdc_pkg::TIMEOUT_W-1:0];
                end
                trdc_pkg::CFG_HARDWARE_READY: begin
                    r_cfg.hardware_ready <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/trdc_step.sv -----
// Next-state and event logic for one command word of the tank controller.
// Purely combinational; depends on trdc_pkg.
module trdc_step #(
    parameter int TIMER_BITS = 16
) (
    input  trdc_pkg::t_state         i_state,
    input  logic [TIMER_BITS-1:0]    i_elapsed,
    input  trdc_pkg::t_cfg           i_cfg,
    input  logic [2:0]               i_command,
    input  logic                     i_level_full,
    input  logic                     i_sensor_error,
    input  logic                     i_inlet_fault,
    input  logic                     i_outlet_fault,
    output trdc_pkg::t_state         o_state,
    output logic [TIMER_BITS-1:0]    o_elapsed,
    output trdc_pkg::t_lev           o_level_event,
    output trdc_pkg::t_act           o_action_event
);

    localparam int CMP_W = (TIMER_BITS > trdc_pkg::TIMEOUT_W) ? TIMER_BITS
                                                               : trdc_pkg::TIMEOUT_W;

    typedef struct packed {
        trdc_pkg::t_state st;
        trdc_pkg::t_act   act;
        trdc_pkg::t_lev   lev;
    } t_chk;

    // drop the refill; close the inlet unless it has failed
    function automatic trdc_pkg::t_state end_st(input trdc_pkg::t_state s,
                                                input logic in_fail);
        trdc_pkg::t_state r;
        r = s;
        if (!in_fail) r.inlet = 1'b0;
        r.refill = 1'b0;
        return r;
    endfunction

    function automatic trdc_pkg::t_act end_code(input trdc_pkg::t_state s,
                                                input logic in_fail);
        if (!s.refill) return trdc_pkg::ACT_NONE;
        return in_fail ? trdc_pkg::ACT_INLET_CLOSE_FAIL : trdc_pkg::ACT_REFILL_STOP;
    endfunction

    function automatic t_chk check_level(input trdc_pkg::t_state s,
                                         input logic full,
                                         input logic err,
                                         input logic [trdc_pkg::CONFIRM_W-1:0] confirm,
                                         input logic in_fail,
                                         input logic out_fail);
        t_chk r;
        r.st  = s;
        r.act = trdc_pkg::ACT_NONE;
        r.lev = trdc_pkg::LEV_NONE;
        if (s.drain) return r;
        if (err) begin
            r.act = (s.refill && in_fail) ? trdc_pkg::ACT_INLET_CLOSE_FAIL
                                          : trdc_pkg::ACT_SENSOR_FAIL;
            r.st = end_st(s, in_fail);
            r.st.monitor = 1'b0;
            return r;
        end
        if (!s.level_known || (full != s.last_level)) begin
            r.lev = full ? trdc_pkg::LEV_NORMAL : trdc_pkg::LEV_LOW;
            r.st.last_level  = full;
            r.st.level_known = 1'b1;
        end
        if (full) begin
            r.st.low_count = '0;
            if (s.refill) begin
                r.act = end_code(r.st, in_fail);
                r.st  = end_st(r.st, in_fail);
            end
            r.st.fault = 1'b0;
            return r;
        end
        if (r.st.low_count < confirm) r.st.low_count = r.st.low_count + 1'b1;
        if ((r.st.low_count >= confirm) && !r.st.refill && !r.st.fault) begin
            if (out_fail) begin
                r.st.fault = 1'b1;
                r.act = trdc_pkg::ACT_OUTLET_CLOSE_FAIL;
            end else begin
                r.st.outlet = 1'b0;
                if (in_fail) begin
                    r.st.fault = 1'b1;
                    r.act = trdc_pkg::ACT_INLET_OPEN_FAIL;
                end else begin
                    r.st.inlet  = 1'b1;
                    r.st.refill = 1'b1;
                    r.act = trdc_pkg::ACT_REFILL_START;
                end
            end
        end
        return r;
    endfunction

    logic                  in_fail;
    logic                  out_fail;
    logic [TIMER_BITS-1:0] elapsed_inc;
    logic                  timed_out;
    t_chk                  chk;
    trdc_pkg::t_act        stop_code;
    trdc_pkg::t_state      st;
    logic [TIMER_BITS-1:0] el;
    trdc_pkg::t_lev        lev;
    trdc_pkg::t_act        act;

    assign in_fail  = i_inlet_fault || !i_cfg.hardware_ready;
    assign out_fail = i_outlet_fault || !i_cfg.hardware_ready;
    assign elapsed_inc = (i_elapsed == '1) ? i_elapsed : i_elapsed + 1'b1;
    assign timed_out = CMP_W'(elapsed_inc) >= CMP_W'(i_cfg.refill_timeout_ticks);

    always_comb begin
        st  = i_state;
        el  = i_elapsed;
        lev = trdc_pkg::LEV_NONE;
        act = trdc_pkg::ACT_NONE;
        chk = '0;
        stop_code = end_code(i_state, in_fail);
        case (trdc_pkg::t_cmd'(i_command))
            trdc_pkg::CMD_TICK: begin
                if (i_state.refill) begin
                    el = elapsed_inc;
                    if (timed_out) begin
                        st.fault = 1'b1;
                        st = end_st(st, in_fail);
                        act = in_fail ? trdc_pkg::ACT_INLET_CLOSE_FAIL
                                      : trdc_pkg::ACT_TIMEOUT;
                    end
                end
            end
            trdc_pkg::CMD_SAMPLE: begin
                if (i_state.monitor) begin
                    chk = check_level(i_state, i_level_full, i_sensor_error,
                                      i_cfg.confirm_samples, in_fail, out_fail);
                    st  = chk.st;
                    act = chk.act;
                    lev = chk.lev;
                end
            end
            trdc_pkg::CMD_START_MON: begin
                if (!i_cfg.hardware_ready) begin
                    act = trdc_pkg::ACT_NOT_READY;
                end else begin
                    st.monitor     = 1'b1;
                    st.level_known = 1'b0;
                    st.low_count   = '0;
                    st.fault       = 1'b0;
                    chk = check_level(st, i_level_full, i_sensor_error,
                                      i_cfg.confirm_samples, in_fail, out_fail);
                    st  = chk.st;
                    lev = chk.lev;
                    act = (chk.act != trdc_pkg::ACT_NONE) ? chk.act
                                                          : trdc_pkg::ACT_MON_START;
                end
            end
            trdc_pkg::CMD_STOP_MON: begin
                st.monitor = 1'b0;
                st = end_st(st, in_fail);
                act = (stop_code != trdc_pkg::ACT_NONE) ? stop_code
                                                        : trdc_pkg::ACT_MON_STOP;
            end
            trdc_pkg::CMD_START_DRAIN: begin
                st = end_st(st, in_fail);
                if (!out_fail) begin
                    st.outlet = 1'b1;
                    st.drain  = 1'b1;
                    act = trdc_pkg::ACT_DRAIN_START;
                end else begin
                    st.drain = 1'b0;
                    act = trdc_pkg::ACT_DRAIN_FAIL;
                end
                if (stop_code == trdc_pkg::ACT_INLET_CLOSE_FAIL) act = stop_code;
            end
            trdc_pkg::CMD_STOP_DRAIN: begin
                if (!out_fail) st.outlet = 1'b0;
                st.drain = 1'b0;
                act = trdc_pkg::ACT_DRAIN_STOP;
            end
            default: begin
            end
        endcase
        // timer only runs during a refill
        if (!st.refill) el = '0;
    end

    assign o_state        = st;
    assign o_elapsed      = el;
    assign o_level_event  = lev;
    assign o_action_event = act;

endmodule

// ----- rtl/core/trdc_checker.sv -----
// Port-level checker for the tank refill and drain controller core, with bind.
// Depends on trdc_pkg and tank_refill_drain_controller_core_defines.svh.
`include "tank_refill_drain_controller_core_defines.svh"

module trdc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_inlet_open,
    input logic       o_outlet_open,
    input logic       o_refilling,
    input logic       o_draining,
    input logic       o_fault_latched,
    input logic       o_monitoring,
    input logic [1:0] o_level_event,
    input logic [3:0] o_action_event
);

    `TRDC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_action_event) && $stable(o_level_event) && $stable(o_inlet_open), "stalled result word changed")
    `TRDC_ASSERT_NOW(a_refill_valves, i_clk, i_rst_n, o_out_valid && o_refilling, o_inlet_open && !o_outlet_open, "refill without inlet open and outlet closed")
    `TRDC_ASSERT_NOW(a_refill_mode, i_clk, i_rst_n, o_out_valid && o_refilling, o_monitoring && !o_draining, "refill outside monitoring or during drain")
    `TRDC_ASSERT_NOW(a_timeout_fault, i_clk, i_rst_n, o_out_valid && (o_action_event == trdc_pkg::ACT_TIMEOUT), o_fault_latched && !o_refilling, "timeout without fault latch")
    `TRDC_ASSERT_NOW(a_start_refill, i_clk, i_rst_n, o_out_valid && (o_action_event == trdc_pkg::ACT_REFILL_START), o_refilling && (o_level_event != trdc_pkg::LEV_NORMAL), "refill start without refill")

endmodule

bind tank_refill_drain_controller_core trdc_checker u_trdc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_inlet_open    (o_inlet_open),
    .o_outlet_open   (o_outlet_open),
    .o_refilling     (o_refilling),
    .o_draining      (o_draining),
    .o_fault_latched (o_fault_latched),
    .o_monitoring    (o_monitoring),
    .o_level_event   (o_level_event),
    .o_action_event  (o_action_event)
);
